// ===== hw/rtl/bof_pkg.sv =====
// shared types, constants and the bernstein weight table for the outline flattener
// depends on nothing; every other file uses it
package bof_pkg;

	localparam int COORD_W    = 24;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_LINE  = 2'd1,
		OP_QUAD  = 2'd2,
		OP_CUBIC = 2'd3
	} op_t;

	// flags that travel with a point down the pipeline
	typedef struct packed {
		logic start;
		logic last;
	} tag_t;

	// one entry of the result queue
	typedef struct packed {
		coord_t x;
		coord_t y;
		tag_t   tag;
	} pnt_t;

	// weight of control point k at step i of s, all on a common denominator of s cubed;
	// quadratic weights carry an extra factor s, move and line put everything on the end point
	function automatic int bern_weight(input int s, input op_t op, input int k, input int i);
		int u;
		int w;
		u = s - i;
		w = 0;
		case (op)
			OP_QUAD: begin
				case (k)
					0: w = u * u * s;
					1: w = 2 * i * u * s;
					3: w = i * i * s;
					default: w = 0;
				endcase
			end
			OP_CUBIC: begin
				case (k)
					0: w = u * u * u;
					1: w = 3 * i * u * u;
					2: w = 3 * i * i * u;
					3: w = i * i * i;
					default: w = 0;
				endcase
			end
			default: begin
				w = (k == 3) ? s * s * s : 0;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/bof_if.sv =====
// valid/ready channel interfaces: path commands in, polyline points out
// depends on bof_pkg for the coordinate type
interface bof_cmd_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           op;
	bof_pkg::coord_t      ctrl1_x;
	bof_pkg::coord_t      ctrl1_y;
	bof_pkg::coord_t      ctrl2_x;
	bof_pkg::coord_t      ctrl2_y;
	bof_pkg::coord_t      end_x;
	bof_pkg::coord_t      end_y;

	modport source (output valid, op, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		input ready);
	modport sink (input valid, op, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
		output ready);
endinterface

interface bof_pnt_if;
	logic                 valid;
	logic                 ready;
	bof_pkg::coord_t      out_x;
	bof_pkg::coord_t      out_y;
	logic                 contour_start;
	logic                 last;

	modport source (output valid, out_x, out_y, contour_start, last, input ready);
	modport sink (input valid, out_x, out_y, contour_start, last, output ready);
endinterface

// ===== hw/rtl/bof_axis.sv =====
// one coordinate axis of the point datapath: weighted sum of four points, then
// round-to-nearest division by a constant via reciprocal multiply and one correction
// depends on bof_pkg
module bof_axis #(
	parameter int DEN = 125,
	parameter int WW  = 7
) (
	input  logic            clk,
	input  bof_pkg::coord_t pt [4],
	input  logic [WW-1:0]   wt [4],
	output bof_pkg::coord_t res
);
	import bof_pkg::*;

	// widths and reciprocal constants, all worked out at elaboration
	localparam int PRW = COORD_W + WW + 1;
	localparam int SW  = PRW + 2;
	localparam int C   = $clog2(DEN);
	localparam int MW  = COORD_W + C;
	localparam int K   = 25 + C;
	localparam int J   = (C >= 2) ? C - 2 : 0;
	localparam int AW  = MW - J;
	localparam int RBW = 26;
	localparam int PW  = AW + RBW;
	localparam logic [63:0]  RECIP_64 = (64'd1 << K) / 64'(DEN);
	localparam logic [RBW-1:0] RECIP = RBW'(RECIP_64);
	localparam logic [MW-1:0]  HALF  = MW'(DEN / 2);
	localparam logic [MW:0]    DEN_W = (MW+1)'(DEN);

	logic signed [PRW-1:0] prod_s1 [4];
	logic signed [SW-1:0]  sum_s2;
	logic                  neg_s3, neg_s4, neg_s5;
	logic [MW-1:0]         mag_s3, mag_s4;
	logic [COORD_W-1:0]    est_s4, quo_s5;

	logic [SW-1:0]  abs_v;
	logic [AW-1:0]  top_v;
	logic [PW-1:0]  rprod_v;
	logic [MW:0]    back_v;
	logic [MW:0]    rem_v;

	// stage 1: four products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= PRW'(pt[k]) * $signed(PRW'({1'b0, wt[k]}));
		end
	end

	// stage 2: weighted sum
	always_ff @(posedge clk) begin
		sum_s2 <= SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]) + SW'(prod_s1[3]);
	end

	// stage 3: sign and magnitude with half the denominator added for rounding
	assign abs_v = sum_s2[SW-1] ? SW'(-sum_s2) : SW'(sum_s2);

	always_ff @(posedge clk) begin
		neg_s3 <= sum_s2[SW-1];
		mag_s3 <= MW'(abs_v) + HALF;
	end

	// stage 4: quotient estimate, low by at most one
	assign top_v   = AW'(mag_s3 >> J);
	assign rprod_v = PW'(top_v) * PW'(RECIP);

	always_ff @(posedge clk) begin
		neg_s4 <= neg_s3;
		mag_s4 <= mag_s3;
		est_s4 <= COORD_W'(rprod_v >> (K - J));
	end

	// stage 5: remainder check fixes the estimate
	assign back_v = (MW+1)'(est_s4) * DEN_W;
	assign rem_v  = {1'b0, mag_s4} - back_v;

	always_ff @(posedge clk) begin
		neg_s5 <= neg_s4;
		quo_s5 <= est_s4 + COORD_W'(rem_v >= DEN_W);
	end

	// restore the sign
	assign res = neg_s5 ? coord_t'(-quo_s5) : coord_t'(quo_s5);

endmodule

// ===== hw/rtl/bezier_outline_flattener_top.sv =====
// outline flattener top level: current-point state, point sequencer, the two axis
// datapaths and the result queue
// depends on bof_pkg, bof_if.sv and bof_axis
//
//  port   dir  handshake     item
//  cmd    in   valid/ready   op, ctrl1_x/y, ctrl2_x/y, end_x/y
//  pnt    out  valid/ready   out_x, out_y, contour_start, last
//
// a move or line issues one point, a curve with an open contour SEGMENTS points, one
// per cycle from the point sequencer unless the credit count holds issue; the next
// command is taken in the cycle of the last issue.
// a point passes the five datapath stages and the queue before it reaches the output.
// arst_n clears the current point, the contour flag, the sequencer and the queue.
// an eight-entry result queue with a credit count absorbs output stalls; issue pauses
// once eight points are outstanding.
module bezier_outline_flattener_top #(
	parameter int SEGMENTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	bof_cmd_if.sink   cmd,
	bof_pnt_if.source pnt
);
	import bof_pkg::*;

	localparam int DEN = SEGMENTS * SEGMENTS * SEGMENTS;
	localparam int WW  = $clog2(DEN + 1);
	localparam int IW  = $clog2(SEGMENTS + 1);
	localparam logic [IW-1:0] I_LAST = IW'(SEGMENTS);
	localparam int CW  = $clog2(FIFO_DEPTH + 1);
	localparam logic [CW-1:0] CRED_MAX = CW'(FIFO_DEPTH);

	// architectural state
	coord_t cur_x_q, cur_y_q;
	logic   open_q;

	// sequencer
	logic          busy_q;
	op_t           op_q;
	logic          start_q;
	logic [IW-1:0] i_q;
	logic [WW-1:0] w_q [4];
	coord_t        px_q [4];
	coord_t        py_q [4];

	// pipeline tags
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	// result queue
	pnt_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      occ_q, cred_q;

	op_t           op_in;
	logic          accept, issue, last_pt, emits, pop;
	op_t           w_op;
	int            w_i;
	logic [WW-1:0] w_next [4];
	coord_t        res_x, res_y;

	// handshake and issue control
	assign op_in   = op_t'(cmd.op);
	assign last_pt = (op_q == OP_MOVE) || (op_q == OP_LINE) || (i_q == I_LAST);
	assign issue   = busy_q && (cred_q < CRED_MAX);
	assign cmd.ready = !busy_q || (issue && last_pt);
	assign accept  = cmd.valid && cmd.ready;
	assign emits   = (op_in == OP_MOVE) || (op_in == OP_LINE) || open_q;
	assign pop     = pnt.valid && pnt.ready;

	// weights for the next point to issue
	always_comb begin
		w_op = accept ? op_in : op_q;
		w_i  = accept ? 1 : int'(i_q) + 1;
		for (int k = 0; k < 4; k++) begin
			w_next[k] = WW'(bern_weight(SEGMENTS, w_op, k, w_i));
		end
	end

	// current point and contour flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			open_q  <= 1'b0;
		end else if (accept && emits) begin
			cur_x_q <= cmd.end_x;
			cur_y_q <= cmd.end_y;
			open_q  <= 1'b1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (accept) begin
			busy_q <= emits;
			i_q    <= IW'(1);
		end else if (issue) begin
			if (last_pt) begin
				busy_q <= 1'b0;
			end else begin
				i_q <= i_q + IW'(1);
			end
		end
	end

	// command operands and weights
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_in;
			start_q <= (op_in == OP_MOVE) || ((op_in == OP_LINE) && !open_q);
			px_q[0] <= cur_x_q;
			py_q[0] <= cur_y_q;
			px_q[1] <= cmd.ctrl1_x;
			py_q[1] <= cmd.ctrl1_y;
			px_q[2] <= cmd.ctrl2_x;
			py_q[2] <= cmd.ctrl2_y;
			px_q[3] <= cmd.end_x;
			py_q[3] <= cmd.end_y;
		end
		if (accept || (issue && !last_pt)) begin
			w_q <= w_next;
		end
	end

	// datapath, one instance per axis
	bof_axis #(.DEN(DEN), .WW(WW)) u_axis_x (
		.clk (clk),
		.pt  (px_q),
		.wt  (w_q),
		.res (res_x)
	);

	bof_axis #(.DEN(DEN), .WW(WW)) u_axis_y (
		.clk (clk),
		.pt  (py_q),
		.wt  (w_q),
		.res (res_y)
	);

	// valid bits alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// point flags alongside the datapath
	always_ff @(posedge clk) begin
		tag_s1.start <= start_q;
		tag_s1.last  <= last_pt;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		tag_s5 <= tag_s4;
	end

	// result queue pointers, fill count and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			cred_q   <= '0;
		end else begin
			if (vld_s5) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			occ_q  <= occ_q + CW'(vld_s5) - CW'(pop);
			cred_q <= cred_q + CW'(issue) - CW'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (vld_s5) begin
			fifo_q[wr_ptr_q].x   <= res_x;
			fifo_q[wr_ptr_q].y   <= res_y;
			fifo_q[wr_ptr_q].tag <= tag_s5;
		end
	end

	// output channel
	assign pnt.valid         = (occ_q != '0);
	assign pnt.out_x         = fifo_q[rd_ptr_q].x;
	assign pnt.out_y         = fifo_q[rd_ptr_q].y;
	assign pnt.contour_start = fifo_q[rd_ptr_q].tag.start;
	assign pnt.last          = fifo_q[rd_ptr_q].tag.last;

endmodule

// ===== test/flatten_checker.sv =====
// watches the command and point channels of the outline flattener, predicts each point
// from the accepted commands and compares it field by field with what the block emits
// depends on bof_pkg and the channel interfaces in bof_if.sv
module flatten_checker #(
	parameter int SEGMENTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	bof_cmd_if   cmd,
	bof_pnt_if   pnt,
	output int   fails,
	output int   pending
);
	import bof_pkg::*;

	// predictor copy of the pen position and the contour flag
	coord_t pen_x;
	coord_t pen_y;
	logic   contour_open;

	// points still owed by the block, oldest first
	pnt_t expected_pts[$];
	pnt_t oldest;

	// divide, rounding to nearest with ties away from zero
	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// work out the points one command gives and move the pen
	function automatic void flatten_command(input op_t op, input coord_t c1x, input coord_t c1y,
			input coord_t c2x, input coord_t c2y, input coord_t ex, input coord_t ey);
		longint u;
		longint t;
		longint den;
		longint sx;
		longint sy;
		pnt_t   p;
		if (op == OP_MOVE || op == OP_LINE) begin
			p.x = ex;
			p.y = ey;
			p.tag.start = (op == OP_MOVE) || !contour_open;
			p.tag.last = 1'b1;
			expected_pts.insert(expected_pts.size(), p);
			contour_open = 1'b1;
			pen_x = ex;
			pen_y = ey;
			return;
		end
		// a curve with no open contour is dropped without touching the pen
		if (!contour_open)
			return;
		for (int i = 1; i <= SEGMENTS; i++) begin
			t = i;
			u = SEGMENTS - i;
			if (op == OP_QUAD) begin
				den = longint'(SEGMENTS) * SEGMENTS;
				sx = longint'(pen_x) * u * u + longint'(c1x) * 2 * t * u + longint'(ex) * t * t;
				sy = longint'(pen_y) * u * u + longint'(c1y) * 2 * t * u + longint'(ey) * t * t;
			end else begin
				den = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
				sx = longint'(pen_x) * u * u * u + longint'(c1x) * 3 * t * u * u
					+ longint'(c2x) * 3 * t * t * u + longint'(ex) * t * t * t;
				sy = longint'(pen_y) * u * u * u + longint'(c1y) * 3 * t * u * u
					+ longint'(c2y) * 3 * t * t * u + longint'(ey) * t * t * t;
			end
			p.x = coord_t'(round_div(sx, den));
			p.y = coord_t'(round_div(sy, den));
			p.tag.start = 1'b0;
			p.tag.last = (i == SEGMENTS);
			expected_pts.insert(expected_pts.size(), p);
		end
		pen_x = ex;
		pen_y = ey;
	endfunction

	// predict on every accepted command, compare every accepted point
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x = '0;
			pen_y = '0;
			contour_open = 1'b0;
			expected_pts.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (cmd.valid && cmd.ready)
				flatten_command(op_t'(cmd.op), cmd.ctrl1_x, cmd.ctrl1_y, cmd.ctrl2_x,
					cmd.ctrl2_y, cmd.end_x, cmd.end_y);
			if (pnt.valid && pnt.ready) begin
				if (expected_pts.size() == 0) begin
					$error("point with no expectation: out_x %0d out_y %0d",
						$signed(pnt.out_x), $signed(pnt.out_y));
					fails++;
				end else begin
					oldest = expected_pts.pop_front();
					if (pnt.out_x !== oldest.x) begin
						$error("out_x expected %0d got %0d", $signed(oldest.x),
							$signed(pnt.out_x));
						fails++;
					end
					if (pnt.out_y !== oldest.y) begin
						$error("out_y expected %0d got %0d", $signed(oldest.y),
							$signed(pnt.out_y));
						fails++;
					end
					if (pnt.contour_start !== oldest.tag.start) begin
						$error("contour_start expected %0b got %0b", oldest.tag.start,
							pnt.contour_start);
						fails++;
					end
					if (pnt.last !== oldest.tag.last) begin
						$error("last expected %0b got %0b", oldest.tag.last, pnt.last);
						fails++;
					end
				end
			end
			pending <= expected_pts.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the outline flattener: clock, reset, command stimulus, point-side
// stalls and the verdict; checking is done by flatten_checker
// depends on bof_pkg, bof_if.sv, flatten_checker.sv and bezier_outline_flattener_top
module tb_top;
	import bof_pkg::*;

	localparam int SEGMENTS    = 5;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_WAIT  = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam coord_t COORD_MAX = coord_t'(24'h7FFFFF);
	localparam coord_t COORD_MIN = coord_t'(24'h800000);

	logic clk = 1'b0;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycle_count = 0;

	// stall control shared between the stimulus and the point-side process
	bit src_quiet  = 1'b0;
	bit sink_quiet = 1'b0;
	int hold_req   = 0;
	int hold_done  = 0;

	bof_cmd_if cmd_ch ();
	bof_pnt_if pnt_ch ();

	bezier_outline_flattener_top #(
		.SEGMENTS(SEGMENTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.pnt(pnt_ch)
	);

	flatten_checker #(
		.SEGMENTS(SEGMENTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.pnt(pnt_ch),
		.fails(fails),
		.pending(pending)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// coordinate with weight on the extremes and on small values
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3, 4: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic coord_t junk();
		return coord_t'($urandom());
	endfunction

	// offer one command item and hold it until accepted
	task automatic send_cmd(input op_t op, input coord_t c1x, input coord_t c1y,
			input coord_t c2x, input coord_t c2y, input coord_t ex, input coord_t ey);
		if (!src_quiet && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.op      <= op;
		cmd_ch.ctrl1_x <= c1x;
		cmd_ch.ctrl1_y <= c1y;
		cmd_ch.ctrl2_x <= c2x;
		cmd_ch.ctrl2_y <= c2y;
		cmd_ch.end_x   <= ex;
		cmd_ch.end_y   <= ey;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	// mostly curves, with moves and lines to open and restart contours
	task automatic send_random_cmd();
		int   r;
		op_t  op;
		r = $urandom_range(0, 19);
		if (r < 2)
			op = OP_MOVE;
		else if (r < 5)
			op = OP_LINE;
		else if (r < 12)
			op = OP_QUAD;
		else
			op = OP_CUBIC;
		send_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
	endtask

	// stop offering and wait for every outstanding point
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// point side: random stalls, runs of ready, and a long hold on request
	initial begin
		pnt_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != hold_done) begin
				pnt_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else if (sink_quiet || $urandom_range(0, 3) != 0) begin
				pnt_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				pnt_ch.ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.op      <= OP_MOVE;
		cmd_ch.ctrl1_x <= '0;
		cmd_ch.ctrl1_y <= '0;
		cmd_ch.ctrl2_x <= '0;
		cmd_ch.ctrl2_y <= '0;
		cmd_ch.end_x   <= '0;
		cmd_ch.end_y   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// curves before any contour is open give nothing
		send_cmd(OP_QUAD, junk(), junk(), junk(), junk(), junk(), junk());
		send_cmd(OP_CUBIC, junk(), junk(), junk(), junk(), junk(), junk());
		// line with no open contour starts one, the next line continues it
		send_cmd(OP_LINE, junk(), junk(), junk(), junk(), 24'sd100, -24'sd200);
		send_cmd(OP_LINE, junk(), junk(), junk(), junk(), COORD_MAX, COORD_MAX);
		// curves across the full range, unused control fields filled with noise
		send_cmd(OP_QUAD, COORD_MIN, COORD_MIN, junk(), junk(), COORD_MIN, COORD_MAX);
		send_cmd(OP_CUBIC, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
		// move while a contour is open restarts it
		send_cmd(OP_MOVE, junk(), junk(), junk(), junk(), COORD_MIN, COORD_MIN);
		send_cmd(OP_CUBIC, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		send_cmd(OP_QUAD, '0, '0, junk(), junk(), -24'sd1, -24'sd1);
		send_cmd(OP_CUBIC, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1);
		send_cmd(OP_LINE, junk(), junk(), junk(), junk(), '0, '0);
		// small values, rounding on both sides of zero
		send_cmd(OP_QUAD, 24'sd3, -24'sd7, junk(), junk(), -24'sd13, 24'sd11);
		send_cmd(OP_CUBIC, -24'sd1, 24'sd1, 24'sd2, -24'sd2, -24'sd3, 24'sd4);
		send_cmd(OP_MOVE, junk(), junk(), junk(), junk(), COORD_MAX, COORD_MIN);
		send_cmd(OP_MOVE, junk(), junk(), junk(), junk(), '0, '0);
		send_cmd(OP_CUBIC, '0, '0, '0, '0, '0, '0);
		send_cmd(OP_LINE, junk(), junk(), junk(), junk(), -24'sd1, '0);
		send_cmd(OP_QUAD, COORD_MAX, COORD_MIN, junk(), junk(), COORD_MIN, COORD_MAX);

		// random traffic with idling on both sides
		repeat (100) send_random_cmd();

		// point side holds off while commands keep coming, so the block backs up
		src_quiet = 1'b1;
		hold_req++;
		repeat (30) send_random_cmd();
		src_quiet = 1'b0;

		// pause until everything is out
		drain();

		// a stretch with no idling at all
		src_quiet = 1'b1;
		sink_quiet = 1'b1;
		repeat (50) send_random_cmd();
		src_quiet = 1'b0;
		sink_quiet = 1'b0;

		repeat (70) send_random_cmd();

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
